/* src/bpe_pkg.sv */
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and helpers for the bezier point evaluator
// Fixed point widths, control point and weight types, the degree code and
// the narrow 16.16 multiply used to form the Bernstein weights.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // field widths of the beats
  localparam int FRAC_W  = 16;
  localparam int COORD_W = 32;
  localparam int T_W     = 17;
  // weights stay well inside 24 bits signed for any t in 17 bits
  localparam int WGT_W   = 24;
  localparam int NPTS    = 4;

  typedef logic signed [WGT_W-1:0]   wgt_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef pt_t  [NPTS-1:0] pt_vec_t;
  typedef wgt_t [NPTS-1:0] wgt_vec_t;

  // one beat between the weight pipe and the blend pipe
  typedef struct packed {
    wgt_vec_t w;
    pt_vec_t  p;
  } blend_in_t;

  // curve degree
  typedef enum logic {
    CMD_QUAD  = 1'b0,
    CMD_CUBIC = 1'b1
  } cmd_t;

  localparam wgt_t FIX_ONE = wgt_t'(1 << FRAC_W);

  // 16.16 multiply of two weights: full product, floor shift, keep WGT_W bits
  function automatic wgt_t fx_mul(input wgt_t a, input wgt_t b);
    logic signed [2*WGT_W-1:0] prod;
    prod = (2*WGT_W)'(a) * (2*WGT_W)'(b);
    return prod[FRAC_W +: WGT_W];
  endfunction

endpackage

/* src/bpe_in_if.sv */
// ----------------------------------------------------------------------------
// bpe_in_if: input channel of the bezier point evaluator
// Valid/ready channel carrying the degree, the curve parameter and four points.
// ----------------------------------------------------------------------------
interface bpe_in_if;
  import bpe_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [T_W-1:0]     param_t;
  logic signed [COORD_W-1:0] p0_x;
  logic signed [COORD_W-1:0] p0_y;
  logic signed [COORD_W-1:0] p1_x;
  logic signed [COORD_W-1:0] p1_y;
  logic signed [COORD_W-1:0] p2_x;
  logic signed [COORD_W-1:0] p2_y;
  logic signed [COORD_W-1:0] p3_x;
  logic signed [COORD_W-1:0] p3_y;

  modport source (
    output valid, command, param_t, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    input  ready
  );

  modport sink (
    input  valid, command, param_t, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    output ready
  );
endinterface

/* src/bpe_out_if.sv */
// ----------------------------------------------------------------------------
// bpe_out_if: result channel of the bezier point evaluator
// Valid/ready channel carrying the x and y of one curve point.
// ----------------------------------------------------------------------------
interface bpe_out_if;
  import bpe_pkg::*;

  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (
    output valid, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y,
    output ready
  );
endinterface

/* src/bezier_point_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// bezier_point_evaluator_unit: quadratic or cubic bezier point evaluator
// Returns the point of the curve at t for each beat, signed 16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per curve point: the degree (0 quadratic with
//   three points, 1 cubic with four), t in unsigned 1.16 and the control points.
//   out_ch returns one beat with point_x and point_y for every input beat,
//   in order. Products truncate toward minus infinity, sums wrap at 32 bits.
//   The path holds six register stages, the three stage weight pipe
//   followed by the three stage blend pipe. Throughput is one beat per
//   cycle while the receiver keeps out_ch.ready high.
//   Each stage holds a valid bit, so empty stages keep filling while the
//   receiver stalls; in_ch.ready falls only when all six stages are full
//   and the output beat is not taken. Nothing is lost or repeated.
//   A synchronous low rst_n clears all valid bits; no state is kept
//   between beats.
// ----------------------------------------------------------------------------
module bezier_point_evaluator_unit (
  input  logic          clk,
  input  logic          rst_n,
  bpe_in_if.sink        in_ch,
  bpe_out_if.source     out_ch
);
  import bpe_pkg::*;

  pt_vec_t   in_pts;
  blend_in_t wgt_data;
  logic      wgt_valid;
  logic      wgt_ready;
  coord_t    res_x;
  coord_t    res_y;

  // gather the control points of the beat
  always_comb begin
    in_pts[0] = '{x: in_ch.p0_x, y: in_ch.p0_y};
    in_pts[1] = '{x: in_ch.p1_x, y: in_ch.p1_y};
    in_pts[2] = '{x: in_ch.p2_x, y: in_ch.p2_y};
    in_pts[3] = '{x: in_ch.p3_x, y: in_ch.p3_y};
  end

  // bernstein weights
  bpe_weight u_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.command),
    .in_t      (in_ch.param_t),
    .in_pts    (in_pts),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_data  (wgt_data)
  );

  // weighted sum of the points
  bpe_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .in_data   (wgt_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (res_x),
    .out_y     (res_y)
  );

  assign out_ch.point_x = res_x;
  assign out_ch.point_y = res_y;

endmodule

/* src/bpe_weight.sv */
// ----------------------------------------------------------------------------
// bpe_weight: three stage Bernstein weight pipeline
// Stage 1 forms u, u*u, t*t and u*t, stage 2 the cubic products, stage 3
// picks and scales the four weights for the degree of the beat.
// ----------------------------------------------------------------------------
module bpe_weight (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [bpe_pkg::T_W-1:0] in_t,
  input  bpe_pkg::pt_vec_t    in_pts,
  output logic                out_valid,
  input  logic                out_ready,
  output bpe_pkg::blend_in_t  out_data
);
  import bpe_pkg::*;

  localparam int NSTG = 3;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] ld;

  // stage 1 signals
  wgt_t    t_ext;
  wgt_t    u1_nxt, uu1_nxt, tt1_nxt, ut1_nxt;
  wgt_t    u1_r, t1_r, uu1_r, tt1_r, ut1_r;
  cmd_t    cmd1_r;
  pt_vec_t pts1_r;

  // stage 2 signals
  wgt_t    uuu2_nxt, ttt2_nxt, uut2_nxt, utt2_nxt;
  wgt_t    uuu2_r, ttt2_r, uut2_r, utt2_r;
  wgt_t    uu2_r, tt2_r, ut2_r;
  cmd_t    cmd2_r;
  pt_vec_t pts2_r;

  // stage 3 signals
  wgt_vec_t w3_nxt;
  wgt_vec_t w3_r;
  pt_vec_t  pts3_r;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  // valid bits travel with the data
  always_comb begin
    v_nxt[0] = ld[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = ld[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[NSTG-1];

  // stage 1: u = 1 - t and the squares
  always_comb begin
    t_ext   = wgt_t'({{(WGT_W-T_W){1'b0}}, in_t});
    u1_nxt  = FIX_ONE - t_ext;
    uu1_nxt = fx_mul(u1_nxt, u1_nxt);
    tt1_nxt = fx_mul(t_ext, t_ext);
    ut1_nxt = fx_mul(u1_nxt, t_ext);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      u1_r   <= u1_nxt;
      t1_r   <= t_ext;
      uu1_r  <= uu1_nxt;
      tt1_r  <= tt1_nxt;
      ut1_r  <= ut1_nxt;
      cmd1_r <= cmd_t'(in_cmd);
      pts1_r <= in_pts;
    end
  end

  // stage 2: third order products
  always_comb begin
    uuu2_nxt = fx_mul(uu1_r, u1_r);
    ttt2_nxt = fx_mul(tt1_r, t1_r);
    uut2_nxt = fx_mul(uu1_r, t1_r);
    utt2_nxt = fx_mul(u1_r, tt1_r);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      uuu2_r <= uuu2_nxt;
      ttt2_r <= ttt2_nxt;
      uut2_r <= uut2_nxt;
      utt2_r <= utt2_nxt;
      uu2_r  <= uu1_r;
      tt2_r  <= tt1_r;
      ut2_r  <= ut1_r;
      cmd2_r <= cmd1_r;
      pts2_r <= pts1_r;
    end
  end

  // stage 3: weight select, times two and times three by shift and add
  always_comb begin
    w3_nxt = '0;
    case (cmd2_r)
      CMD_QUAD: begin
        w3_nxt[0] = uu2_r;
        w3_nxt[1] = ut2_r <<< 1;
        w3_nxt[2] = tt2_r;
        w3_nxt[3] = '0;
      end
      CMD_CUBIC: begin
        w3_nxt[0] = uuu2_r;
        w3_nxt[1] = uut2_r + (uut2_r <<< 1);
        w3_nxt[2] = utt2_r + (utt2_r <<< 1);
        w3_nxt[3] = ttt2_r;
      end
      default: begin
        w3_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      w3_r   <= w3_nxt;
      pts3_r <= pts2_r;
    end
  end

  assign out_data = '{w: w3_r, p: pts3_r};

endmodule

/* src/bpe_blend.sv */
// ----------------------------------------------------------------------------
// bpe_blend: three stage weighted sum of the control points
// Stage 1 multiplies each weight with x and y, stage 2 adds pairs,
// stage 3 forms the point and serves as the output register.
// ----------------------------------------------------------------------------
module bpe_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpe_pkg::blend_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bpe_pkg::coord_t    out_x,
  output bpe_pkg::coord_t    out_y
);
  import bpe_pkg::*;

  localparam int NSTG = 3;
  localparam int PROD_W = WGT_W + COORD_W;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] ld;

  logic signed [PROD_W-1:0] prx [NPTS];
  logic signed [PROD_W-1:0] pry [NPTS];
  coord_t tx_nxt [NPTS];
  coord_t ty_nxt [NPTS];
  coord_t tx_r   [NPTS];
  coord_t ty_r   [NPTS];

  coord_t sx01_nxt, sx23_nxt, sy01_nxt, sy23_nxt;
  coord_t sx01_r, sx23_r, sy01_r, sy23_r;
  coord_t px_nxt, py_nxt;
  coord_t px_r, py_r;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  // valid bits travel with the data
  always_comb begin
    v_nxt[0] = ld[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = ld[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[NSTG-1];

  // stage 1: weight times coordinate, floor shift by the fraction width
  always_comb begin
    for (int k = 0; k < NPTS; k++) begin
      prx[k]    = PROD_W'($signed(in_data.w[k])) * PROD_W'($signed(in_data.p[k].x));
      pry[k]    = PROD_W'($signed(in_data.w[k])) * PROD_W'($signed(in_data.p[k].y));
      tx_nxt[k] = prx[k][FRAC_W +: COORD_W];
      ty_nxt[k] = pry[k][FRAC_W +: COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < NPTS; k++) begin
        tx_r[k] <= tx_nxt[k];
        ty_r[k] <= ty_nxt[k];
      end
    end
  end

  // stage 2: pair sums, wrapping
  always_comb begin
    sx01_nxt = tx_r[0] + tx_r[1];
    sx23_nxt = tx_r[2] + tx_r[3];
    sy01_nxt = ty_r[0] + ty_r[1];
    sy23_nxt = ty_r[2] + ty_r[3];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      sx01_r <= sx01_nxt;
      sx23_r <= sx23_nxt;
      sy01_r <= sy01_nxt;
      sy23_r <= sy23_nxt;
    end
  end

  // stage 3: final sum into the output register
  always_comb begin
    px_nxt = sx01_r + sx23_r;
    py_nxt = sy01_r + sy23_r;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  assign out_x = px_r;
  assign out_y = py_r;

`ifndef SYNTHESIS
  // blocked product stage keeps its beat
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !ld[1]) |=> (v_r[0] && $stable(tx_r[0]) && $stable(ty_r[3])))
    else $error("product stage lost its beat while blocked");

  // blocked sum stage keeps its beat
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && !ld[2]) |=> (v_r[1] && $stable(sx01_r) && $stable(sy23_r)))
    else $error("sum stage lost its beat while blocked");

  // a result only appears when the sum stage held a beat
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[2]) |-> $past(v_r[1]))
    else $error("result beat appeared from an empty sum stage");
`endif

endmodule

/* sim/bpe_point_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_point_checker: scoreboard for the bezier point evaluator
// Watches both channels, computes the curve point of every accepted input
// beat and compares each output beat, in order, with the oldest one pending.
// ----------------------------------------------------------------------------
module bpe_point_checker (
  input  logic clk,
  input  logic rst_n,
  bpe_in_if    in_mon,
  bpe_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  import bpe_pkg::*;

  localparam logic [31:0] FX_ONE   = 32'h0001_0000;
  localparam logic [31:0] FX_TWO   = 32'h0002_0000;
  localparam logic [31:0] FX_THREE = 32'h0003_0000;

  // points still owed by the block, oldest first
  pt_t curve_pts_q[$];

  // 16.16 product: full signed product, floor shift by 16, low 32 bits kept
  function automatic logic [31:0] fx16_mul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] prod;
    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return prod[47:16];
  endfunction

  // bernstein blend of the control points at parameter t
  function automatic pt_t eval_curve_point(input cmd_t deg, input logic [T_W-1:0] t,
                                           input pt_vec_t p);
    logic [31:0] tw, u, uu, tt, sx, sy;
    logic [31:0] w [NPTS];
    pt_t res;
    tw = 32'(t);
    u  = FX_ONE - tw;
    uu = fx16_mul(u, u);
    tt = fx16_mul(tw, tw);
    if (deg == CMD_QUAD) begin
      // fourth point gets a zero weight, so it drops out
      w[0] = uu;
      w[1] = fx16_mul(fx16_mul(u, tw), FX_TWO);
      w[2] = tt;
      w[3] = '0;
    end else begin
      w[0] = fx16_mul(uu, u);
      w[1] = fx16_mul(FX_THREE, fx16_mul(uu, tw));
      w[2] = fx16_mul(FX_THREE, fx16_mul(u, tt));
      w[3] = fx16_mul(tt, tw);
    end
    sx = '0;
    sy = '0;
    for (int i = 0; i < NPTS; i++) begin
      sx = sx + fx16_mul(w[i], p[i].x);
      sy = sy + fx16_mul(w[i], p[i].y);
    end
    res.x = sx;
    res.y = sy;
    return res;
  endfunction

  // check output beats, then predict from input beats
  always @(posedge clk) begin
    pt_t     want;
    pt_vec_t pts;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (curve_pts_q.size() == 0) begin
          $error("output beat with no point pending: x %h y %h",
                 out_mon.point_x, out_mon.point_y);
          fail_count <= fail_count + 1;
        end else begin
          want = curve_pts_q.pop_front();
          if (out_mon.point_x !== want.x || out_mon.point_y !== want.y) begin
            if (out_mon.point_x !== want.x)
              $error("point_x mismatch: expected %h, got %h", want.x, out_mon.point_x);
            if (out_mon.point_y !== want.y)
              $error("point_y mismatch: expected %h, got %h", want.y, out_mon.point_y);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pts[0].x = in_mon.p0_x;
        pts[0].y = in_mon.p0_y;
        pts[1].x = in_mon.p1_x;
        pts[1].y = in_mon.p1_y;
        pts[2].x = in_mon.p2_x;
        pts[2].y = in_mon.p2_y;
        pts[3].x = in_mon.p3_x;
        pts[3].y = in_mon.p3_y;
        curve_pts_q.push_back(eval_curve_point(cmd_t'(in_mon.command), in_mon.param_t, pts));
      end
    end
    outstanding <= curve_pts_q.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bezier point evaluator
// Sends directed curve points (parameter ends, beyond one, coordinate
// extremes) and then random ones over several idle and stall mixes; the
// scoreboard instance predicts and compares every output beat.
// ----------------------------------------------------------------------------
module testbench;
  import bpe_pkg::*;

  typedef struct {
    cmd_t            deg;
    logic [T_W-1:0]  t;
    pt_vec_t         p;
  } curve_job_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending_pts;
  int   snd_idle_pct;
  int   rcv_stall_pct;

  bpe_in_if  in_ch();
  bpe_out_if out_ch();

  bezier_point_evaluator_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bpe_point_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (mismatches),
    .outstanding (pending_pts)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // random coordinate: wide, moderate, extreme or whole-number values
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0, 1, 2: return $urandom;
      3, 4, 5: return 32'($urandom_range(32'h01FF_FFFF)) - 32'h0100_0000;
      6: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom & 32'hFFFF_0000;
    endcase
  endfunction

  // random curve point request, mostly within the curve, some beyond one
  function automatic curve_job_t rand_job();
    curve_job_t j;
    j.deg = $urandom_range(1) ? CMD_CUBIC : CMD_QUAD;
    case ($urandom_range(9))
      0: j.t = '0;
      1: j.t = 17'd65536;
      8: j.t = 17'($urandom_range(131071, 65537));
      9: j.t = 17'($urandom_range(131071));
      default: j.t = 17'($urandom_range(65536));
    endcase
    for (int i = 0; i < NPTS; i++) begin
      j.p[i].x = rand_coord();
      j.p[i].y = rand_coord();
    end
    return j;
  endfunction

  // one input beat, with random idle cycles ahead of it; valid stays high after
  task automatic send_job(input curve_job_t j);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= j.deg;
    in_ch.param_t <= j.t;
    in_ch.p0_x    <= j.p[0].x;
    in_ch.p0_y    <= j.p[0].y;
    in_ch.p1_x    <= j.p[1].x;
    in_ch.p1_y    <= j.p[1].y;
    in_ch.p2_x    <= j.p[2].x;
    in_ch.p2_y    <= j.p[2].y;
    in_ch.p3_x    <= j.p[3].x;
    in_ch.p3_y    <= j.p[3].y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold off the sender until every pending point has come out
  task automatic drain_points();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pts != 0) @(posedge clk);
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus
  initial begin
    logic [T_W-1:0] t_set [8] = '{17'd0, 17'd1, 17'd16384, 17'd32768,
                                  17'd65535, 17'd65536, 17'd65537, 17'd131071};
    logic [31:0]    xtr [4]   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0};
    curve_job_t     j;
    int             phase_snd [4] = '{0, 87, 0, 29};
    int             phase_rcv [4] = '{0, 0, 87, 29};

    rst_n         = 1'b0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    in_ch.valid   = 1'b0;
    in_ch.command = 1'b0;
    in_ch.param_t = '0;
    in_ch.p0_x    = '0;
    in_ch.p0_y    = '0;
    in_ch.p1_x    = '0;
    in_ch.p1_y    = '0;
    in_ch.p2_x    = '0;
    in_ch.p2_y    = '0;
    in_ch.p3_x    = '0;
    in_ch.p3_y    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // parameter sweep with a fixed hull; the nonzero fourth point must not
    // show up in quadratic results
    j.p[0].x = 32'h0;         j.p[0].y = 32'h0;
    j.p[1].x = 32'h0001_0000; j.p[1].y = 32'h0003_0000;
    j.p[2].x = 32'h0004_0000; j.p[2].y = 32'hFFFE_0000;
    j.p[3].x = 32'hFFFB_0000; j.p[3].y = 32'h0006_8000;
    for (int i = 0; i < 8; i++) begin
      j.t   = t_set[i];
      j.deg = CMD_QUAD;
      send_job(j);
      j.deg = CMD_CUBIC;
      send_job(j);
    end

    // coordinate extremes, products and sums overflow
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < NPTS; i++) begin
        j.p[i].x = xtr[(k + i) % 4];
        j.p[i].y = xtr[(k + 3 * i + 1) % 4];
      end
      j.deg = (k % 2) ? CMD_CUBIC : CMD_QUAD;
      j.t   = t_set[(2 * k + 3) % 8];
      send_job(j);
    end

    // random points under each idle and stall mix
    for (int ph = 0; ph < 4; ph++) begin
      drain_points();
      snd_idle_pct  = phase_snd[ph];
      rcv_stall_pct = phase_rcv[ph];
      for (int n = 0; n < 158; n++) send_job(rand_job());
    end

    // let the pipe empty
    drain_points();
    rcv_stall_pct = 0;
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_pts == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* bezier_point_evaluator_unit.f */
src/bpe_pkg.sv
src/bpe_in_if.sv
src/bpe_out_if.sv
src/bpe_weight.sv
src/bpe_blend.sv
src/bezier_point_evaluator_unit.sv
sim/bpe_point_checker.sv
sim/testbench.sv
